>>> rtl/core/ebga_pkg.sv
// Shared constants, command/status structs and codes for the embedding-bag
// gradient accumulator. No dependencies; compiled first.
`default_nettype none

package ebga_pkg;

    // Table geometry and bag limit
    localparam int NUM_ROWS = 1024;
    localparam int EMB_DIM  = 128;
    localparam int MAX_BAG  = 256;

    // Field widths
    localparam int ROW_W  = 10;
    localparam int COL_W  = 7;
    localparam int GRAD_W = 32;
    localparam int BAG_W  = 9;

    localparam int DEPTH     = NUM_ROWS * EMB_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int DIV_CNT_W = $clog2(GRAD_W);

    // Opcode of an input word
    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic ready;     // input side may take a word
        logic take;      // input word accepted this cycle
        logic clear_wr;  // write zero at the clear pointer
        logic commit;    // write back the sum and load the output register
    } ebga_cmd_t;

    typedef struct packed {
        logic div_needed;  // word at the input needs the divider
        logic div_busy;    // divider still iterating
        logic out_free;    // output register can take a result this cycle
        logic clear_last;  // clear pointer is at the last entry
    } ebga_status_t;

endpackage

`default_nettype wire

>>> rtl/core/ebga_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on ebga_pkg.
`default_nettype none

interface ebga_req_if;
    import ebga_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [GRAD_W-1:0] grad_elem;
    logic [BAG_W-1:0]         bag_len;

    modport source (output valid, output op, output row, output column,
                    output grad_elem, output bag_len, input ready);
    modport sink   (input valid, input op, input row, input column,
                    input grad_elem, input bag_len, output ready);
endinterface

interface ebga_rsp_if;
    import ebga_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] value;
    logic                     saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/embedding_bag_grad_accumulate_unit.sv
// Top level of the embedding-bag gradient accumulator.
// Depends on ebga_pkg, ebga_if, ebga_ctrl and ebga_datapath.
`default_nettype none

// Scatters embedding-bag output gradients into a 1024 x 128 table of signed
// Q16.16 accumulators held in on-chip memory (entry row * 128 + column).
// An accumulate word (op 0) adds grad_elem to the entry, first divided by
// bag_len (truncating toward zero) when mean_mode is set and the bag holds
// more than one index; zero bag length counts as one, lengths above 256 clamp
// to 256. The sum saturates to the 32-bit signed range and the response word
// reports saturated = 1 when it clipped. A read word (op 1) returns the entry
// unchanged. Every request produces exactly one response word.
// After reset a clearing pass zeroes all 131072 entries, one per cycle;
// req.ready stays low throughout, while cfg writes are taken as usual.
// mean_mode is written through cfg_we/cfg_data; the user must write it only
// while idle, which the block itself does not enforce.
// A word is taken with its memory read, then read-modify-written, with the
// bit-serial divider (one quotient bit per cycle) in between in mean mode with
// a bag longer than one. No new word is taken before the current one commits.
// A finished result sits in the output register, so the next request is taken
// while the response waits; a new result is held back only while it is full.

module embedding_bag_grad_accumulate_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_data,
    ebga_req_if.sink   req,
    ebga_rsp_if.source rsp
);
    import ebga_pkg::*;

    ebga_cmd_t    cmd;
    ebga_status_t status;

    ebga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .status    (status),
        .cmd       (cmd)
    );

    ebga_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .op         (req.op),
        .row        (req.row),
        .column     (req.column),
        .grad_elem  (req.grad_elem),
        .bag_len    (req.bag_len),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .value      (rsp.value),
        .saturated  (rsp.saturated)
    );

    assign req.ready = cmd.ready;

endmodule

`default_nettype wire

>>> rtl/core/ebga_div.sv
// Bit-serial restoring divider: signed dividend by a small positive divisor,
// quotient truncated toward zero, one quotient bit per cycle. Depends on ebga_pkg.
`default_nettype none

module ebga_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ebga_pkg::GRAD_W-1:0]       dividend_mag,
    input  wire logic                              negate,
    input  wire logic [ebga_pkg::BAG_W-1:0]        divisor,
    output logic                                   busy,
    output logic signed [ebga_pkg::GRAD_W-1:0]     quotient
);
    import ebga_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [GRAD_W-1:0]    quo_reg;
    logic [BAG_W-1:0]     rem_reg;
    logic [BAG_W-1:0]     div_reg;
    logic                 neg_reg;

    logic [BAG_W-1:0]     rem_shift;
    logic [BAG_W-1:0]     rem_sub;
    logic                 fits;

    // Remainder stays below the divisor, so its top bit is free for the shift.
    assign rem_shift = {rem_reg[BAG_W-2:0], quo_reg[GRAD_W-1]};
    assign fits      = (rem_shift >= div_reg);
    assign rem_sub   = rem_shift - div_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(GRAD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend_mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= negate;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[GRAD_W-2:0], fits};
            rem_reg <= fits ? rem_sub : rem_shift;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? $signed(~quo_reg + GRAD_W'(1)) : $signed(quo_reg);

endmodule

`default_nettype wire

>>> rtl/core/ebga_datapath.sv
// Datapath: accumulator memory, clear pointer, bag-length divider,
// saturating adder and output register. Depends on ebga_pkg and ebga_div.
`default_nettype none

module ebga_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ebga_pkg::ebga_cmd_t               cmd,
    output ebga_pkg::ebga_status_t                 status,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_data,
    input  wire logic                              op,
    input  wire logic [ebga_pkg::ROW_W-1:0]        row,
    input  wire logic [ebga_pkg::COL_W-1:0]        column,
    input  wire logic signed [ebga_pkg::GRAD_W-1:0] grad_elem,
    input  wire logic [ebga_pkg::BAG_W-1:0]        bag_len,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [ebga_pkg::GRAD_W-1:0]     value,
    output logic                                   saturated
);
    import ebga_pkg::*;

    localparam logic signed [GRAD_W-1:0] SAT_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic signed [GRAD_W-1:0] SAT_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

    logic [GRAD_W-1:0] grad_mem [DEPTH];

    // Control registers
    logic              mean_mode_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;

    // Item registers
    logic                     op_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     in_range_reg;
    logic                     use_div_reg;
    logic signed [GRAD_W-1:0] grad_reg;
    logic signed [GRAD_W-1:0] rd_data_reg;
    logic signed [GRAD_W-1:0] value_reg;
    logic                     sat_reg;

    // Input-side decode
    logic [BAG_W-1:0]  len_eff;
    logic              div_needed;
    logic [ADDR_W-1:0] addr_in;
    logic              in_range;
    logic [GRAD_W-1:0] grad_mag;

    // Divider
    logic                     div_busy;
    logic signed [GRAD_W-1:0] div_q;

    // Update path
    logic signed [GRAD_W-1:0] addend;
    logic signed [GRAD_W:0]   sum_ext;
    logic                     ovf;
    logic signed [GRAD_W-1:0] sum_val;
    logic signed [GRAD_W-1:0] result;
    logic                     result_sat;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [GRAD_W-1:0]        mem_wdata;

    // Zero length acts as one; longer bags clamp to the maximum.
    always_comb
    begin
        len_eff = bag_len;
        if (bag_len == '0)
            len_eff = BAG_W'(1);
        else if (bag_len > BAG_W'(MAX_BAG))
            len_eff = BAG_W'(MAX_BAG);
    end

    assign div_needed = mean_mode_reg && (len_eff > BAG_W'(1));
    assign in_range   = ({1'b0, row} < (ROW_W+1)'(NUM_ROWS))
                     && ({1'b0, column} < (COL_W+1)'(EMB_DIM));
    assign addr_in    = ADDR_W'(ADDR_W'(row) * ADDR_W'(EMB_DIM) + ADDR_W'(column));
    assign grad_mag   = grad_elem[GRAD_W-1] ? (~grad_elem + GRAD_W'(1))
                                            : grad_elem;

    ebga_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.take && div_needed),
        .dividend_mag (grad_mag),
        .negate       (grad_elem[GRAD_W-1]),
        .divisor      (len_eff),
        .busy         (div_busy),
        .quotient     (div_q)
    );

    // Saturating add against the stored entry
    assign addend  = use_div_reg ? div_q : grad_reg;
    assign sum_ext = {rd_data_reg[GRAD_W-1], rd_data_reg} + {addend[GRAD_W-1], addend};
    assign ovf     = (sum_ext[GRAD_W] != sum_ext[GRAD_W-1]);
    assign sum_val = ovf ? (sum_ext[GRAD_W] ? SAT_MIN : SAT_MAX) : sum_ext[GRAD_W-1:0];

    always_comb
    begin
        result     = '0;
        result_sat = 1'b0;
        if (in_range_reg)
        begin
            if (op_reg == OP_READ)
                result = rd_data_reg;
            else
            begin
                result     = sum_val;
                result_sat = ovf;
            end
        end
    end

    // Single write port shared by the clearing pass and write-back
    assign mem_we    = cmd.clear_wr || (cmd.commit && in_range_reg && (op_reg == OP_ACC));
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : addr_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : sum_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grad_mem[mem_waddr] <= mem_wdata;
        if (cmd.take)
            rd_data_reg <= grad_mem[addr_in];
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clear_wr)
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_mode_reg <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mean_mode_reg <= cfg_data;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg       <= op;
            addr_reg     <= addr_in;
            in_range_reg <= in_range;
            use_div_reg  <= div_needed;
            grad_reg     <= grad_elem;
        end
        if (cmd.commit)
        begin
            value_reg <= result;
            sat_reg   <= result_sat;
        end
    end

    assign status.div_needed = div_needed;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

>>> rtl/core/ebga_ctrl.sv
// Controller FSM: clearing pass, word intake, divider wait, write-back.
// Depends on ebga_pkg.
`default_nettype none

module ebga_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire ebga_pkg::ebga_status_t status,
    output ebga_pkg::ebga_cmd_t         cmd
);
    import ebga_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_ADD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.take  = req_valid;
                if (req_valid)
                    state_next = status.div_needed ? ST_DIV : ST_ADD;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // memory read data is valid here; wait for room at the output
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for embedding_bag_grad_accumulate_unit: drives request
// words, predicts each response from a shadow of the gradient table.
// Depends on ebga_pkg, ebga_if and the RTL of the unit.

module testbench;
    import ebga_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_WORDS  = 100;
    localparam int NUM_HOT      = 8;
    // Covers the clearing pass after reset and the divider time of mean-mode
    // words plus stalls, so this leaves a wide margin.
    localparam int TIMEOUT_CYCLES = 900000;

    localparam longint SUM_MAX = 2147483647;
    localparam longint SUM_MIN = -longint'(2147483647) - 1;

    typedef struct packed {
        logic                     op;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         column;
        logic signed [GRAD_W-1:0] grad_elem;
        logic [BAG_W-1:0]         bag_len;
    } grad_word_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] value;
        logic                     saturated;
    } grad_result_t;

    logic clk      = 1'b0;
    logic rst_n    = 1'b1;
    logic cfg_we   = 1'b0;
    logic cfg_data = 1'b0;

    ebga_req_if req_ch ();
    ebga_rsp_if rsp_ch ();

    embedding_bag_grad_accumulate_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow state: accumulator table (absent entry reads as zero, matching the
    // cleared table) and the bench's copy of mean_mode.
    logic signed [GRAD_W-1:0] grad_shadow [int unsigned];
    logic                     mean_div_en = 1'b0;

    grad_word_t   pending_words [$];
    grad_result_t expected_sums [$];

    grad_word_t   next_word;
    grad_word_t   word_on_bus;
    grad_result_t want;
    int           feed_gap;
    int           sink_hold;
    int           sink_stall;
    int           n_wrong = 0;
    bit           quiet_phase = 1'b0;   // both sides run with no idle cycles

    int hot_row [NUM_HOT];
    int hot_col [NUM_HOT];

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Gap before the next word, or stall after a response.
    function automatic int draw_wait();
        if (quiet_phase)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Predicts the response to one accepted word and updates the shadow table.
    function automatic grad_result_t accumulate_model(grad_word_t w);
        int unsigned  slot;
        longint       acc;
        longint       delta;
        longint       total;
        longint       divisor;
        grad_result_t r;
        slot = {w.row, w.column};   // row * EMB_DIM + column
        acc  = grad_shadow.exists(slot) ? longint'(grad_shadow[slot]) : 0;
        r.saturated = 1'b0;
        if (w.op == OP_READ)
        begin
            r.value = acc[GRAD_W-1:0];
            return r;
        end
        // zero length counts as one; oversize bags clamp to MAX_BAG
        if (w.bag_len == 0)
            divisor = 1;
        else if (w.bag_len > MAX_BAG)
            divisor = MAX_BAG;
        else
            divisor = w.bag_len;
        delta = longint'($signed(w.grad_elem));
        if (mean_div_en && divisor > 1)
            delta = delta / divisor;   // truncates toward zero
        total = acc + delta;
        if (total > SUM_MAX)
        begin
            total       = SUM_MAX;
            r.saturated = 1'b1;
        end
        else if (total < SUM_MIN)
        begin
            total       = SUM_MIN;
            r.saturated = 1'b1;
        end
        grad_shadow[slot] = total[GRAD_W-1:0];
        r.value = total[GRAD_W-1:0];
        return r;
    endfunction

    // Request side: predict on acceptance, then present the next pending word
    // after its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.op         <= OP_ACC;
            req_ch.row        <= '0;
            req_ch.column     <= '0;
            req_ch.grad_elem  <= '0;
            req_ch.bag_len    <= '0;
            word_on_bus       <= '0;
            feed_gap          <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_sums.push_back(accumulate_model(word_on_bus));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (feed_gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    feed_gap     <= feed_gap - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    req_ch.op         <= next_word.op;
                    req_ch.row        <= next_word.row;
                    req_ch.column     <= next_word.column;
                    req_ch.grad_elem  <= next_word.grad_elem;
                    req_ch.bag_len    <= next_word.bag_len;
                    req_ch.valid      <= 1'b1;
                    word_on_bus       <= next_word;
                    feed_gap          <= draw_wait();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response side: compare against the oldest prediction, then stall ready
    // for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            sink_hold    <= 0;
        end
        else
        begin
            sink_stall = sink_hold;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected response word, expected none, actual %h/%b",
                             $time, rsp_ch.value, rsp_ch.saturated);
                    n_wrong++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (rsp_ch.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, rsp_ch.value);
                        n_wrong++;
                    end
                    if (rsp_ch.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch, expected %b, actual %b",
                                 $time, want.saturated, rsp_ch.saturated);
                        n_wrong++;
                    end
                end
                sink_stall = draw_wait();
            end
            if (sink_stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                sink_hold    <= sink_stall - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                sink_hold    <= 0;
            end
        end
    end

    task automatic queue_word(input logic op, input int row, input int col,
                              input logic [GRAD_W-1:0] grad, input int bag);
        grad_word_t w;
        w.op         = op;
        w.row        = row[ROW_W-1:0];
        w.column     = col[COL_W-1:0];
        w.grad_elem  = grad;
        w.bag_len    = bag[BAG_W-1:0];
        pending_words.push_back(w);
    endtask

    // Waits until every queued word is accepted and answered, then a short pause.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || req_ch.valid || expected_sums.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mean_mode(input logic mode);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= mode;
        mean_div_en = mode;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    // Mostly read-modify-write traffic on a few hot entries so sums pile up
    // and clip; the rest lands anywhere in the table.
    task automatic queue_random_words(input int count);
        int               k;
        int               h;
        int               row;
        int               col;
        logic             op;
        logic [GRAD_W-1:0] grad;
        int               bag;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                h   = $urandom_range(0, NUM_HOT - 1);
                row = hot_row[h];
                col = hot_col[h];
            end
            else
            begin
                row = $urandom_range(0, NUM_ROWS - 1);
                col = $urandom_range(0, EMB_DIM - 1);
            end
            op = ($urandom_range(0, 9) < 2) ? OP_READ : OP_ACC;
            case ($urandom_range(0, 3))
                0: grad = $urandom;
                1: grad = int'($urandom_range(0, 262143)) - 131072;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: grad = 32'h7FFF_FFFF;
                        1: grad = 32'h8000_0000;
                        2: grad = 32'hFFFF_FFFF;
                        default: grad = 32'h0000_0001;
                    endcase
                end
                default: grad = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: bag = $urandom_range(0, 511);
                1: bag = $urandom_range(1, 4);
                2: bag = $urandom_range(255, 511);
                default: bag = $urandom_range(0, 1);
            endcase
            queue_word(op, row, col, grad, bag);
        end
    endtask

    initial
    begin
        int p;
        hot_row[0] = 0;
        hot_col[0] = 0;
        hot_row[1] = NUM_ROWS - 1;
        hot_col[1] = EMB_DIM - 1;
        for (p = 2; p < NUM_HOT; p++)
        begin
            hot_row[p] = $urandom_range(0, NUM_ROWS - 1);
            hot_col[p] = $urandom_range(0, EMB_DIM - 1);
        end

        // Single reset pulse; the falling edge at time zero drives the request and response channel signals.
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sum mode. The request side stays blocked through the clearing pass.
        write_mean_mode(1'b0);
        queue_word(OP_READ, 0, 0, 32'h0, 1);                      // untouched entry
        queue_word(OP_ACC, 1023, 127, 32'h7FFF_FFFF, 1);          // up to max
        queue_word(OP_ACC, 1023, 127, 32'h0000_0001, 0);          // clips high
        queue_word(OP_ACC, 1023, 127, 32'h8000_0000, 511);        // back to -1
        queue_word(OP_ACC, 0, 0, 32'h8000_0000, 2);               // bag ignored
        queue_word(OP_ACC, 0, 0, 32'hFFFF_FFFF, 256);             // clips low
        queue_word(OP_READ, 1023, 127, 32'h1234_5678, 3);
        queue_word(OP_READ, 0, 0, 32'h0, 0);
        wait_idle();

        // Mean mode: zero length, bag of one, truncation, clamp above MAX_BAG.
        write_mean_mode(1'b1);
        queue_word(OP_ACC, 3, 4, 32'hFFFF_FFF9, 0);               // -7 undivided
        queue_word(OP_ACC, 3, 5, 32'h0000_0005, 1);               // 5 undivided
        queue_word(OP_ACC, 3, 6, 32'hFFFF_FFF9, 2);               // -7/2 -> -3
        queue_word(OP_ACC, 3, 7, 32'h0000_0007, 3);               // 7/3 -> 2
        queue_word(OP_ACC, 3, 8, 32'h8000_0000, 256);
        queue_word(OP_ACC, 3, 9, 32'h7FFF_FFFF, 511);             // clamps to 256
        queue_word(OP_ACC, 3, 10, 32'hFFFF_FFFF, 257);            // -1/256 -> 0
        queue_word(OP_ACC, 5, 9, 32'h7FFF_FFFF, 1);
        queue_word(OP_ACC, 5, 9, 32'h7FFF_FFFF, 2);               // clips high
        queue_word(OP_ACC, 0, 0, 32'h8000_0000, 3);               // clips low
        queue_word(OP_READ, 3, 9, 32'h0, 1);
        queue_word(OP_READ, 5, 9, 32'h0, 1);
        wait_idle();

        // Random phases across both settings, one without idle cycles.
        for (p = 0; p < 6; p++)
        begin
            write_mean_mode((p == 1 || p == 2 || p == 4) ? 1'b1 : 1'b0);
            quiet_phase = (p == 3);
            queue_random_words(PHASE_WORDS);
            wait_idle();
        end
        quiet_phase = 1'b0;

        // Let any stray response show up before the verdict.
        repeat (40) @(posedge clk);
        if (n_wrong == 0 && expected_sums.size() == 0)
        begin
            $display("embedding_bag_grad_accumulate_unit verification clean");
        end
        else
        begin
            $display("embedding_bag_grad_accumulate_unit verification failed");
        end
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("embedding_bag_grad_accumulate_unit verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ebga_pkg.sv
rtl/core/ebga_if.sv
rtl/core/ebga_div.sv
rtl/core/ebga_datapath.sv
rtl/core/ebga_ctrl.sv
rtl/core/embedding_bag_grad_accumulate_unit.sv
tb/testbench.sv
